// ----- hw/rtl/lru_page_frame_table_unit_assert.svh -----
// Assertion macros for the page frame table RTL.
// No dependencies; included by lru_page_frame_table_unit, which carries assertions.
`ifndef LRU_PAGE_FRAME_TABLE_UNIT_ASSERT_SVH
`define LRU_PAGE_FRAME_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define LPFT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPFT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lpft_pkg.sv -----
// Package for the page frame table: field widths, frame count, request kinds, sequencer states.
// No dependencies.
`default_nettype none
package lpft_pkg;
   localparam int KIND_W  = 2;
   localparam int PAGE_W  = 31;
   localparam int FRAME_W = 10;
   // frame count; a power of two, so the bucket hash is the low page bits
   localparam int FRAMES  = 1 << FRAME_W;

   localparam logic [KIND_W-1:0] KIND_FIX   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNFIX = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DIRTY = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_HASH_GO, S_HASH_WAIT, S_HEAD, S_FIRST, S_WALK_RD, S_WALK_CMP,
      S_MISS, S_HIT_RD, S_HIT_UPD, S_UNLINK, S_APPEND, S_APPEND_TAIL, S_EV_RD, S_EV_GET,
      S_RM_HEAD, S_RM_CHK, S_RM_RD, S_RM_CMP, S_RELOAD, S_RELOAD_Q, S_INSTALL, S_DIRTY,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/lru_page_frame_table_unit.sv -----
// Page-to-frame table of a buffer pool with hash bucket chains and LRU order.
// Top level; uses lpft_pkg, lpft_hash, lpft_ram and the assertion macro header.
//
// Requests arrive on req_* (kind, page_number, frame_number); each gives exactly
// one result on rsp_*. A transfer happens on a rising edge with valid high and
// stall low. The block takes one request at a time: req_stall is low only while
// the sequencer is idle, and a finished result sits in the rsp_* registers, so
// the next request is taken while that result waits for the receiver.
// Steps after the accepting edge: a fix or unfix hashes the page, reads the
// bucket head, then reads and compares each chain entry in turn. Any hit updates
// the pin count; a fix hit on a frame other than the most recent one also moves
// it to the LRU tail. An unfix miss goes straight to the response; a miss into a
// free frame installs the page; an eviction unlinks the oldest frame, hashes its
// page, removes it from its bucket chain and rereads the new page's bucket head
// before the install. Mark dirty sets the dirty bit of a frame in use, an unknown
// kind does nothing; the result shows at the end of the response step. One read
// port per memory sets the step count. After reset the bucket head memory is
// swept to null, with req_stall high during the sweep. A stalled result holds,
// and the sequencer waits in its response step for a free output register.
`default_nettype none
`include "lru_page_frame_table_unit_assert.svh"
module lru_page_frame_table_unit #(
   parameter int PIN_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lpft_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [lpft_pkg::PAGE_W-1:0]  req_page_number,
   input  wire logic [lpft_pkg::FRAME_W-1:0] req_frame_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [lpft_pkg::FRAME_W-1:0]      rsp_frame_out,
   output logic                              rsp_ok,
   output logic                              rsp_hit,
   output logic                              rsp_load_needed,
   output logic                              rsp_victim_valid,
   output logic [lpft_pkg::PAGE_W-1:0]       rsp_victim_page,
   output logic                              rsp_victim_writeback
);
   localparam int FRAMES = lpft_pkg::FRAMES;
   localparam int FW = $clog2(FRAMES);
   localparam int IW = $clog2(FRAMES + 1);
   localparam int CW = (IW > lpft_pkg::FRAME_W) ? IW : lpft_pkg::FRAME_W;
   localparam int PW = lpft_pkg::PAGE_W;
   localparam logic [IW-1:0] NIL = IW'(FRAMES);
   localparam logic [FW-1:0] CLR_LAST = FW'(FRAMES - 1);
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   lpft_pkg::state_type state_ff, state_in;

   logic [lpft_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [PW-1:0]                page_ff, page_in;
   logic [lpft_pkg::FRAME_W-1:0] fnum_ff, fnum_in;
   logic [IW-1:0] cur_ff, cur_in, hd_ff, hd_in, p_ff, p_in, n_ff, n_in;
   logic [IW-1:0] fn_ff, fn_in, vf_ff, vf_in;
   logic [FW-1:0] b_ff, b_in, vb_ff, vb_in, clr_ff, clr_in;
   logic [PW-1:0] vpage_ff, vpage_in;
   logic          vdirty_ff, vdirty_in, rm_ff, rm_in, ev_ff, ev_in;
   logic          res_ok_ff, res_ok_in, res_hit_ff, res_hit_in, res_load_ff, res_load_in;
   logic [IW-1:0] lru_head_ff, lru_head_in, lru_tail_ff, lru_tail_in, used_ff, used_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lpft_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic rsp_ok_ff, rsp_ok_in, rsp_hit_ff, rsp_hit_in, rsp_load_ff, rsp_load_in;
   logic rsp_vv_ff, rsp_vv_in, rsp_wb_ff, rsp_wb_in;
   logic [PW-1:0] rsp_vpage_ff, rsp_vpage_in;

   // memory ports
   logic [FW-1:0]       frame_ra, head_ra;
   logic                page_we, dirty_we, pins_we, cnext_we, prev_we, next_we, head_we;
   logic [FW-1:0]       page_wa, dirty_wa, pins_wa, cnext_wa, prev_wa, next_wa, head_wa;
   logic [PW-1:0]       page_wd, page_q;
   logic                dirty_wd, dirty_q;
   logic [PIN_BITS-1:0] pins_wd, pins_q;
   logic [IW-1:0]       cnext_wd, cnext_q, prev_wd, prev_q, next_wd, next_q;
   logic [IW-1:0]       head_wd, head_q;

   logic          hash_start, hash_done;
   logic [FW-1:0] hash_rem;
   logic [CW-1:0] fnum_ext, used_ext, cur_ext;
   logic          dirty_ok, slot_free;

   assign fnum_ext  = CW'(fnum_ff);
   assign used_ext  = CW'(used_ff);
   assign cur_ext   = CW'(cur_ff);
   assign dirty_ok  = (fnum_ext < used_ext);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign frame_ra  = cur_ff[FW-1:0];
   assign head_ra   = (state_ff == lpft_pkg::S_RM_HEAD) ? vb_ff : b_ff;

   lpft_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .value (rm_ff ? vpage_ff : page_ff),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   lpft_ram #(.DEPTH(FRAMES), .WIDTH(PW)) u_page_ram (
      .clock(clock), .wr_en(page_we), .wr_addr(page_wa), .wr_data(page_wd),
      .rd_addr(frame_ra), .rd_data(page_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(1)) u_dirty_ram (
      .clock(clock), .wr_en(dirty_we), .wr_addr(dirty_wa), .wr_data(dirty_wd),
      .rd_addr(frame_ra), .rd_data(dirty_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(PIN_BITS)) u_pins_ram (
      .clock(clock), .wr_en(pins_we), .wr_addr(pins_wa), .wr_data(pins_wd),
      .rd_addr(frame_ra), .rd_data(pins_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(IW)) u_cnext_ram (
      .clock(clock), .wr_en(cnext_we), .wr_addr(cnext_wa), .wr_data(cnext_wd),
      .rd_addr(frame_ra), .rd_data(cnext_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(IW)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(frame_ra), .rd_data(prev_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(IW)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(frame_ra), .rd_data(next_q));
   lpft_ram #(.DEPTH(FRAMES), .WIDTH(IW)) u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_addr(head_ra), .rd_data(head_q));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpft_pkg::S_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = lpft_pkg::S_IDLE;
         end
         lpft_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  lpft_pkg::KIND_FIX:   state_in = lpft_pkg::S_HASH_GO;
                  lpft_pkg::KIND_UNFIX: state_in = lpft_pkg::S_HASH_GO;
                  lpft_pkg::KIND_DIRTY: state_in = lpft_pkg::S_DIRTY;
                  default:              state_in = lpft_pkg::S_RESP;
               endcase
            end
         end
         lpft_pkg::S_HASH_GO:   state_in = lpft_pkg::S_HASH_WAIT;
         lpft_pkg::S_HASH_WAIT: begin
            if (hash_done) state_in = rm_ff ? lpft_pkg::S_RM_HEAD : lpft_pkg::S_HEAD;
         end
         lpft_pkg::S_HEAD:  state_in = lpft_pkg::S_FIRST;
         lpft_pkg::S_FIRST: begin
            state_in = (head_q == NIL) ? lpft_pkg::S_MISS : lpft_pkg::S_WALK_RD;
         end
         lpft_pkg::S_WALK_RD:  state_in = lpft_pkg::S_WALK_CMP;
         lpft_pkg::S_WALK_CMP: begin
            if (page_q == page_ff) state_in = lpft_pkg::S_HIT_RD;
            else if (cnext_q == NIL) state_in = lpft_pkg::S_MISS;
            else state_in = lpft_pkg::S_WALK_RD;
         end
         lpft_pkg::S_MISS: begin
            if (kind_ff != lpft_pkg::KIND_FIX) state_in = lpft_pkg::S_RESP;
            else if (used_ff < NIL) state_in = lpft_pkg::S_INSTALL;
            else if (lru_head_ff < NIL) state_in = lpft_pkg::S_EV_RD;
            else state_in = lpft_pkg::S_RESP;
         end
         lpft_pkg::S_HIT_RD:  state_in = lpft_pkg::S_HIT_UPD;
         lpft_pkg::S_HIT_UPD: begin
            if (kind_ff == lpft_pkg::KIND_FIX && cur_ff != lru_tail_ff)
               state_in = lpft_pkg::S_UNLINK;
            else
               state_in = lpft_pkg::S_RESP;
         end
         lpft_pkg::S_UNLINK: begin
            state_in = ev_ff ? lpft_pkg::S_HASH_GO : lpft_pkg::S_APPEND;
         end
         lpft_pkg::S_APPEND:      state_in = lpft_pkg::S_APPEND_TAIL;
         lpft_pkg::S_APPEND_TAIL: state_in = lpft_pkg::S_RESP;
         lpft_pkg::S_EV_RD:       state_in = lpft_pkg::S_EV_GET;
         lpft_pkg::S_EV_GET:      state_in = lpft_pkg::S_UNLINK;
         lpft_pkg::S_RM_HEAD:     state_in = lpft_pkg::S_RM_CHK;
         lpft_pkg::S_RM_CHK: begin
            if (head_q == vf_ff || head_q == NIL) state_in = lpft_pkg::S_RELOAD;
            else state_in = lpft_pkg::S_RM_RD;
         end
         lpft_pkg::S_RM_RD: state_in = lpft_pkg::S_RM_CMP;
         lpft_pkg::S_RM_CMP: begin
            if (cnext_q == vf_ff || cnext_q == NIL) state_in = lpft_pkg::S_RELOAD;
            else state_in = lpft_pkg::S_RM_RD;
         end
         lpft_pkg::S_RELOAD:   state_in = lpft_pkg::S_RELOAD_Q;
         lpft_pkg::S_RELOAD_Q: state_in = lpft_pkg::S_INSTALL;
         lpft_pkg::S_INSTALL:  state_in = lpft_pkg::S_APPEND_TAIL;
         lpft_pkg::S_DIRTY:    state_in = lpft_pkg::S_RESP;
         lpft_pkg::S_RESP: begin
            if (slot_free) state_in = lpft_pkg::S_IDLE;
         end
         default: state_in = lpft_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in = kind_ff;  page_in = page_ff;  fnum_in = fnum_ff;
      cur_in = cur_ff;  hd_in = hd_ff;  p_in = p_ff;  n_in = n_ff;
      fn_in = fn_ff;  vf_in = vf_ff;  b_in = b_ff;  vb_in = vb_ff;  clr_in = clr_ff;
      vpage_in = vpage_ff;  vdirty_in = vdirty_ff;  rm_in = rm_ff;  ev_in = ev_ff;
      res_ok_in = res_ok_ff;  res_hit_in = res_hit_ff;  res_load_in = res_load_ff;
      lru_head_in = lru_head_ff;  lru_tail_in = lru_tail_ff;  used_in = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_frame_in = rsp_frame_ff;  rsp_ok_in = rsp_ok_ff;  rsp_hit_in = rsp_hit_ff;
      rsp_load_in = rsp_load_ff;  rsp_vv_in = rsp_vv_ff;  rsp_wb_in = rsp_wb_ff;
      rsp_vpage_in = rsp_vpage_ff;
      hash_start = 1'b0;
      page_we = 1'b0;  page_wa = cur_ff[FW-1:0];  page_wd = page_ff;
      dirty_we = 1'b0; dirty_wa = cur_ff[FW-1:0]; dirty_wd = 1'b0;
      pins_we = 1'b0;  pins_wa = cur_ff[FW-1:0];  pins_wd = PIN_BITS'(1);
      cnext_we = 1'b0; cnext_wa = cur_ff[FW-1:0]; cnext_wd = hd_ff;
      prev_we = 1'b0;  prev_wa = cur_ff[FW-1:0];  prev_wd = lru_tail_ff;
      next_we = 1'b0;  next_wa = cur_ff[FW-1:0];  next_wd = NIL;
      head_we = 1'b0;  head_wa = b_ff;            head_wd = cur_ff;
      case (state_ff)
         lpft_pkg::S_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = NIL;
            clr_in  = clr_ff + 1'b1;
         end
         lpft_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in     = req_kind;
               page_in     = req_page_number;
               fnum_in     = req_frame_number;
               res_ok_in   = 1'b0;
               res_hit_in  = 1'b0;
               res_load_in = 1'b0;
               ev_in       = 1'b0;
               rm_in       = 1'b0;
            end
         end
         lpft_pkg::S_HASH_GO: hash_start = 1'b1;
         lpft_pkg::S_HASH_WAIT: begin
            if (hash_done) begin
               if (rm_ff) vb_in = hash_rem;
               else       b_in  = hash_rem;
            end
         end
         lpft_pkg::S_FIRST: begin
            cur_in = head_q;
            hd_in  = head_q;
         end
         lpft_pkg::S_WALK_CMP: begin
            if (page_q == page_ff) begin
               res_ok_in  = 1'b1;
               res_hit_in = (kind_ff == lpft_pkg::KIND_FIX);
            end else begin
               cur_in = cnext_q;
            end
         end
         lpft_pkg::S_MISS: begin
            if (kind_ff == lpft_pkg::KIND_FIX) begin
               if (used_ff < NIL) begin
                  cur_in      = used_ff;
                  used_in     = used_ff + 1'b1;
                  res_ok_in   = 1'b1;
                  res_load_in = 1'b1;
               end else if (lru_head_ff < NIL) begin
                  cur_in      = lru_head_ff;
                  vf_in       = lru_head_ff;
                  ev_in       = 1'b1;
                  res_ok_in   = 1'b1;
                  res_load_in = 1'b1;
               end
            end
         end
         lpft_pkg::S_HIT_UPD: begin
            p_in    = prev_q;
            n_in    = next_q;
            pins_we = 1'b1;
            if (kind_ff == lpft_pkg::KIND_FIX)
               pins_wd = (pins_q != PIN_MAX) ? pins_q + 1'b1 : pins_q;
            else
               pins_wd = (pins_q != '0) ? pins_q - 1'b1 : pins_q;
         end
         lpft_pkg::S_UNLINK: begin
            if (p_ff < NIL) begin
               next_we = 1'b1;
               next_wa = p_ff[FW-1:0];
               next_wd = n_ff;
            end else begin
               lru_head_in = n_ff;
            end
            if (n_ff < NIL) begin
               prev_we = 1'b1;
               prev_wa = n_ff[FW-1:0];
               prev_wd = p_ff;
            end else begin
               lru_tail_in = p_ff;
            end
         end
         lpft_pkg::S_APPEND: begin
            prev_we = 1'b1;
            next_we = 1'b1;
         end
         lpft_pkg::S_APPEND_TAIL: begin
            if (lru_tail_ff < NIL) begin
               next_we = 1'b1;
               next_wa = lru_tail_ff[FW-1:0];
               next_wd = cur_ff;
            end else begin
               lru_head_in = cur_ff;
            end
            lru_tail_in = cur_ff;
         end
         lpft_pkg::S_EV_GET: begin
            vpage_in  = page_q;
            vdirty_in = dirty_q;
            p_in      = prev_q;
            n_in      = next_q;
            fn_in     = cnext_q;
            rm_in     = 1'b1;
         end
         lpft_pkg::S_RM_CHK: begin
            if (head_q == vf_ff) begin
               head_we = 1'b1;
               head_wa = vb_ff;
               head_wd = fn_ff;
            end else begin
               cur_in = head_q;
            end
         end
         lpft_pkg::S_RM_CMP: begin
            if (cnext_q == vf_ff) begin
               cnext_we = 1'b1;
               cnext_wd = fn_ff;
            end else begin
               cur_in = cnext_q;
            end
         end
         lpft_pkg::S_RELOAD_Q: begin
            hd_in  = head_q;
            cur_in = vf_ff;
            rm_in  = 1'b0;
         end
         lpft_pkg::S_INSTALL: begin
            page_we  = 1'b1;
            dirty_we = 1'b1;
            pins_we  = 1'b1;
            cnext_we = 1'b1;
            head_we  = 1'b1;
            prev_we  = 1'b1;
            next_we  = 1'b1;
         end
         lpft_pkg::S_DIRTY: begin
            res_ok_in = dirty_ok;
            dirty_we  = dirty_ok;
            dirty_wa  = fnum_ext[FW-1:0];
            dirty_wd  = 1'b1;
         end
         lpft_pkg::S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == lpft_pkg::KIND_DIRTY) rsp_frame_in = fnum_ff;
               else if (res_ok_ff) rsp_frame_in = cur_ext[lpft_pkg::FRAME_W-1:0];
               else rsp_frame_in = '0;
               rsp_ok_in    = res_ok_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_load_in  = res_load_ff;
               rsp_vv_in    = ev_ff;
               rsp_vpage_in = ev_ff ? vpage_ff : '0;
               rsp_wb_in    = ev_ff && vdirty_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpft_pkg::S_CLEAR;
         clr_ff       <= '0;
         lru_head_ff  <= NIL;
         lru_tail_ff  <= NIL;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lru_head_ff  <= lru_head_in;
         lru_tail_ff  <= lru_tail_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;  page_ff <= page_in;  fnum_ff <= fnum_in;
      cur_ff <= cur_in;  hd_ff <= hd_in;  p_ff <= p_in;  n_ff <= n_in;
      fn_ff <= fn_in;  vf_ff <= vf_in;  b_ff <= b_in;  vb_ff <= vb_in;
      vpage_ff <= vpage_in;  vdirty_ff <= vdirty_in;  rm_ff <= rm_in;  ev_ff <= ev_in;
      res_ok_ff <= res_ok_in;  res_hit_ff <= res_hit_in;  res_load_ff <= res_load_in;
      rsp_frame_ff <= rsp_frame_in;  rsp_ok_ff <= rsp_ok_in;  rsp_hit_ff <= rsp_hit_in;
      rsp_load_ff <= rsp_load_in;  rsp_vv_ff <= rsp_vv_in;  rsp_wb_ff <= rsp_wb_in;
      rsp_vpage_ff <= rsp_vpage_in;
   end

   assign req_stall            = (state_ff != lpft_pkg::S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_out        = rsp_frame_ff;
   assign rsp_ok               = rsp_ok_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_load_needed      = rsp_load_ff;
   assign rsp_victim_valid     = rsp_vv_ff;
   assign rsp_victim_page      = rsp_vpage_ff;
   assign rsp_victim_writeback = rsp_wb_ff;

   `LPFT_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= NIL, "frame count overran")
   `LPFT_ASSERT_IMP(a_lru_ends, clock, reset, state_ff == lpft_pkg::S_IDLE,
      (lru_head_ff == NIL) == (lru_tail_ff == NIL), "LRU head and tail disagree")
   `LPFT_ASSERT_NXT(a_resp_hold, clock, reset,
      state_ff == lpft_pkg::S_RESP && rsp_valid_ff && rsp_stall,
      state_ff == lpft_pkg::S_RESP, "result dropped while output stalled")
   `LPFT_ASSERT_IMP(a_hit_load, clock, reset, rsp_valid_ff,
      !(rsp_hit_ff && rsp_load_ff), "hit and load both set")
endmodule
`default_nettype wire

// ----- hw/rtl/lpft_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module lpft_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/lpft_hash.sv -----
// Bucket hash unit: page id modulo the frame count, a power of two, so the low
// page bits, registered with a done pulse. Uses lpft_pkg.
`default_nettype none
module lpft_hash (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lpft_pkg::PAGE_W-1:0] value,
   output logic                             done,
   output logic [lpft_pkg::FRAME_W-1:0]     rem
);
   logic [lpft_pkg::FRAME_W-1:0] rem_ff, rem_in;
   logic                         done_ff, done_in;

   always_comb begin
      rem_in  = start ? value[lpft_pkg::FRAME_W-1:0] : rem_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

// ----- test/tb_lru_page_frame_table_unit.sv -----
// Self-checking testbench for lru_page_frame_table_unit: a scoreboard class predicts each
// result from its own copy of the page table; a task drives requests, an initial block stalls results.
// Depends on lpft_pkg and the RTL of the block.
`default_nettype none
module tb_lru_page_frame_table_unit;
   typedef logic [lpft_pkg::KIND_W-1:0]  kind_type;
   typedef logic [lpft_pkg::PAGE_W-1:0]  page_type;
   typedef logic [lpft_pkg::FRAME_W-1:0] frame_type;

   localparam int NFRAMES = 1024;
   localparam logic [10:0] NIL = 11'd1024;
   localparam logic [15:0] PIN_TOP = 16'hFFFF;
   localparam kind_type KIND_NONE = 2'd3;

   typedef struct packed {
      frame_type frame;
      logic      ok;
      logic      hit;
      logic      load;
      logic      vvalid;
      page_type  vpage;
      logic      wback;
   } page_result_type;

   class page_table_board;
      page_type          page_of[NFRAMES];
      bit                dirty[NFRAMES];
      logic [15:0]       pins[NFRAMES];
      logic [10:0]       bucket[NFRAMES];
      logic [10:0]       chain[NFRAMES];
      logic [10:0]       prv[NFRAMES];
      logic [10:0]       nxt[NFRAMES];
      logic [10:0]       oldest, newest, used;
      page_result_type   pending[$];
      int                errors, checked, evictions, hits;

      function new();
         for (int i = 0; i < NFRAMES; i++) begin
            page_of[i] = '0; dirty[i] = 0; pins[i] = '0; bucket[i] = NIL;
            chain[i] = '0; prv[i] = '0; nxt[i] = '0;
         end
         oldest = NIL; newest = NIL; used = '0;
         errors = 0; checked = 0; evictions = 0; hits = 0;
      endfunction

      function logic [10:0] lookup(page_type pg);
         logic [10:0] f;
         f = bucket[pg % NFRAMES];
         for (int s = 0; s < NFRAMES && f != NIL; s++) begin
            if (page_of[f] == pg) return f;
            f = chain[f];
         end
         return NIL;
      endfunction

      function void detach(logic [10:0] f);
         logic [10:0] p, n;
         p = prv[f]; n = nxt[f];
         if (p != NIL) nxt[p] = n; else oldest = n;
         if (n != NIL) prv[n] = p; else newest = p;
         prv[f] = NIL; nxt[f] = NIL;
      endfunction

      function void to_newest(logic [10:0] f);
         prv[f] = newest; nxt[f] = NIL;
         if (newest != NIL) nxt[newest] = f; else oldest = f;
         newest = f;
      endfunction

      function void unchain(logic [10:0] f);
         int          b;
         logic [10:0] p;
         b = page_of[f] % NFRAMES;
         p = bucket[b];
         if (p == f) begin
            bucket[b] = chain[f];
            return;
         end
         for (int s = 0; s < NFRAMES && p != NIL; s++) begin
            if (chain[p] == f) begin
               chain[p] = chain[f];
               return;
            end
            p = chain[p];
         end
      endfunction

      function void load_frame(logic [10:0] f, page_type pg);
         page_of[f] = pg; pins[f] = 16'd1; dirty[f] = 0;
         chain[f] = bucket[pg % NFRAMES];
         bucket[pg % NFRAMES] = f;
         to_newest(f);
      endfunction

      // predict the result of one accepted request and queue it
      function void note_request(kind_type kind, page_type pg, frame_type fn);
         page_result_type r;
         logic [10:0] f;
         r = '0;
         if (kind == lpft_pkg::KIND_FIX) begin
            f = lookup(pg);
            if (f != NIL) begin
               if (pins[f] < PIN_TOP) pins[f]++;
               if (f != newest) begin
                  detach(f); to_newest(f);
               end
               r.frame = f[9:0]; r.ok = 1; r.hit = 1; hits++;
            end else if (used < NFRAMES) begin
               f = used; used++;
               load_frame(f, pg);
               r.frame = f[9:0]; r.ok = 1; r.load = 1;
            end else if (oldest != NIL) begin
               f = oldest;
               r.vvalid = 1; r.vpage = page_of[f]; r.wback = dirty[f];
               detach(f); unchain(f); load_frame(f, pg);
               r.frame = f[9:0]; r.ok = 1; r.load = 1; evictions++;
            end
         end else if (kind == lpft_pkg::KIND_UNFIX) begin
            f = lookup(pg);
            if (f != NIL) begin
               if (pins[f] > 0) pins[f]--;
               r.frame = f[9:0]; r.ok = 1;
            end
         end else if (kind == lpft_pkg::KIND_DIRTY) begin
            r.frame = fn;
            if ({1'b0, fn} < used) begin
               dirty[fn] = 1; r.ok = 1;
            end
         end
         pending.insert(pending.size(), r);
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_result(page_result_type got);
         page_result_type exp;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result frame %0d", got.frame));
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.frame !== exp.frame)
            report($sformatf("frame_out %0d, want %0d", got.frame, exp.frame));
         if (got.ok !== exp.ok) report($sformatf("ok %b, want %b", got.ok, exp.ok));
         if (got.hit !== exp.hit) report($sformatf("hit %b, want %b", got.hit, exp.hit));
         if (got.load !== exp.load)
            report($sformatf("load_needed %b, want %b", got.load, exp.load));
         if (got.vvalid !== exp.vvalid)
            report($sformatf("victim_valid %b, want %b", got.vvalid, exp.vvalid));
         if (got.vpage !== exp.vpage)
            report($sformatf("victim_page %0h, want %0h", got.vpage, exp.vpage));
         if (got.wback !== exp.wback)
            report($sformatf("victim_writeback %b, want %b", got.wback, exp.wback));
      endtask
   endclass

   logic      clock = 0;
   logic      reset = 1;
   logic      req_valid = 0;
   logic      req_stall;
   kind_type  req_kind = '0;
   page_type  req_page_number = '0;
   frame_type req_frame_number = '0;
   logic      rsp_valid;
   logic      rsp_stall = 0;
   frame_type rsp_frame_out;
   logic      rsp_ok, rsp_hit, rsp_load_needed, rsp_victim_valid;
   page_type  rsp_victim_page;
   logic      rsp_victim_writeback;

   page_table_board board = new();
   bit        no_idle = 0;
   int        sent = 0;
   page_type  recent_pages[$];

   lru_page_frame_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_page_number(req_page_number), .req_frame_number(req_frame_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_frame_out(rsp_frame_out),
      .rsp_ok(rsp_ok), .rsp_hit(rsp_hit), .rsp_load_needed(rsp_load_needed),
      .rsp_victim_valid(rsp_victim_valid), .rsp_victim_page(rsp_victim_page),
      .rsp_victim_writeback(rsp_victim_writeback)
   );

   always #5 clock = ~clock;

   task send_request(kind_type kind, page_type pg, frame_type fn);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_kind <= kind; req_page_number <= pg; req_frame_number <= fn;
      req_valid <= 1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(kind, pg, fn);
      sent++;
   endtask

   function page_type fresh_page();
      page_type pg;
      pg = page_type'($urandom);
      // crowd some pages into a few buckets to grow the chains
      if ($urandom_range(0, 4) == 0) pg[9:0] = 10'($urandom_range(0, 15));
      recent_pages.insert(recent_pages.size(), pg);
      if (recent_pages.size() > 64) void'(recent_pages.pop_front());
      return pg;
   endfunction

   function page_type known_page();
      if (recent_pages.size() == 0) return fresh_page();
      return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
   endfunction

   // result side: random stalls, check each transfer
   initial begin
      int n;
      page_result_type got;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 9);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_frame_out, rsp_ok, rsp_hit, rsp_load_needed, rsp_victim_valid,
                 rsp_victim_page, rsp_victim_writeback};
         board.check_result(got);
      end
   end

   initial begin
      int r;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, chains in bucket zero, unfix at zero pins, unused frames
      send_request(lpft_pkg::KIND_FIX, 31'd0, 10'd0);
      send_request(lpft_pkg::KIND_FIX, 31'd0, 10'd0);
      send_request(lpft_pkg::KIND_FIX, 31'd1024, 10'h3FF);
      send_request(lpft_pkg::KIND_FIX, 31'h7FFFFFFF, 10'd0);
      send_request(lpft_pkg::KIND_FIX, 31'd2048, 10'd0);
      send_request(lpft_pkg::KIND_FIX, 31'd1024, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'd0, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'd0, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'd0, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'd5, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'h7FFFFFFF, 10'd0);
      send_request(lpft_pkg::KIND_DIRTY, 31'h7FFFFFFF, 10'd0);
      send_request(lpft_pkg::KIND_DIRTY, 31'd0, 10'h3FF);
      send_request(lpft_pkg::KIND_DIRTY, 31'd0, 10'd4);
      send_request(lpft_pkg::KIND_DIRTY, 31'd0, 10'd3);
      send_request(KIND_NONE, 31'h7FFFFFFF, 10'h3FF);
      send_request(lpft_pkg::KIND_FIX, 31'd2048, 10'd0);
      send_request(lpft_pkg::KIND_UNFIX, 31'd1024, 10'd0);
      // random: fill the table, then run on with evictions
      while (sent < 1350) begin
         if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         // while frames remain free, lean on fixes of new pages
         if (board.used < NFRAMES && r >= 70 && $urandom_range(0, 2) != 0) r = 0;
         if (r < 70) begin
            if (board.used < NFRAMES || $urandom_range(0, 1) == 0)
               send_request(lpft_pkg::KIND_FIX, fresh_page(), frame_type'($urandom));
            else
               send_request(lpft_pkg::KIND_FIX, known_page(), frame_type'($urandom));
         end else if (r < 82) begin
            send_request(lpft_pkg::KIND_UNFIX,
                         $urandom_range(0, 4) == 0 ? page_type'($urandom) : known_page(),
                         frame_type'($urandom));
         end else if (r < 95) begin
            if (board.used > 0 && $urandom_range(0, 9) < 7)
               send_request(lpft_pkg::KIND_DIRTY, page_type'($urandom),
                            frame_type'($urandom_range(0, board.used - 1)));
            else
               send_request(lpft_pkg::KIND_DIRTY, page_type'($urandom),
                            frame_type'($urandom));
         end else begin
            send_request(KIND_NONE, page_type'($urandom), frame_type'($urandom));
         end
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d requests, %0d results checked: %0d hits, %0d evictions.",
               sent, board.checked, board.hits, board.evictions);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #30000000;
      $display("Timeout with %0d results outstanding", board.pending.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lpft_pkg.sv
hw/rtl/lpft_ram.sv
hw/rtl/lpft_hash.sv
hw/rtl/lru_page_frame_table_unit.sv
test/tb_lru_page_frame_table_unit.sv
